[design/lfps_pkg.sv]
// shared types and constants for the line-follow pid steering block
package lfps_pkg;

    // field widths fixed by the interface
    localparam int LEVEL_W    = 7;
    localparam int GAIN_W     = 16;
    localparam int ERR_W      = 8;
    localparam int STEER_W    = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEER_LIMIT = 200;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHITE_LEVEL = 3'd0,
        CFG_BLACK_LEVEL = 3'd1,
        CFG_GAIN_PROP   = 3'd2,
        CFG_GAIN_INTEG  = 3'd3,
        CFG_GAIN_DERIV  = 3'd4
    } t_cfg_idx;

    // reset values of the configuration registers
    localparam logic [LEVEL_W-1:0] WHITE_RST      = 7'd0;
    localparam logic [LEVEL_W-1:0] BLACK_RST      = 7'd0;
    localparam logic [GAIN_W-1:0]  GAIN_PROP_RST  = 16'd287;
    localparam logic [GAIN_W-1:0]  GAIN_INTEG_RST = 16'd1229;
    localparam logic [GAIN_W-1:0]  GAIN_DERIV_RST = 16'd4096;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [LEVEL_W-1:0] white_level;
        logic [LEVEL_W-1:0] black_level;
        logic [GAIN_W-1:0]  gain_prop;
        logic [GAIN_W-1:0]  gain_integ;
        logic [GAIN_W-1:0]  gain_deriv;
    } t_cfg;

endpackage

[design/lfps_err.sv]
// input stage: midpoint and error from one light sample, registered
module lfps_err
    import lfps_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [LEVEL_W-1:0]      i_sample,
    input  logic                    i_adv,
    output logic                    o_valid,
    output logic signed [ERR_W-1:0] o_err
);

    logic                      r_valid;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ERR_W-1:0]   span;
    logic signed [ERR_W-1:0]   half;
    logic signed [ERR_W:0]     mid;
    logic signed [ERR_W:0]     err_wide;
    logic                      take;

    // midpoint with the halving truncated toward zero
    always_comb begin
        span     = $signed({1'b0, i_cfg.white_level}) - $signed({1'b0, i_cfg.black_level});
        half     = (span + $signed({{(ERR_W-1){1'b0}}, span[ERR_W-1]})) >>> 1;
        mid      = ERR_W'(half) + $signed({2'b00, i_cfg.black_level});
        err_wide = mid - $signed({2'b00, i_sample});
    end

    // stage moves when empty or when the next stage takes its item
    assign o_ready = !r_valid || i_adv;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (take) begin
            r_err <= err_wide[ERR_W-1:0];
        end
    end

    assign o_valid = r_valid;
    assign o_err   = r_err;

endmodule

[design/lfps_pid.sv]
// pid stage: leaky integral, three products, truncation, saturation, result register
module lfps_pid
    import lfps_pkg::*;
#(
    parameter int GAIN_FRAC_BITS  = 12,
    parameter int INTEG_FRAC_BITS = 8
)(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_valid,
    input  logic signed [ERR_W-1:0]   i_err,
    output logic                      o_adv,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [STEER_W-1:0] o_steer,
    output logic                      o_sat
);

    localparam int IW  = INTEG_FRAC_BITS + 10;
    localparam int SW  = INTEG_FRAC_BITS + 29;
    localparam int FB  = GAIN_FRAC_BITS + INTEG_FRAC_BITS;
    localparam int WW  = SW - FB;
    localparam logic signed [SW-1:0] BIAS = SW'((64'd1 << FB) - 64'd1);
    localparam logic signed [WW-1:0] LIM_HI = WW'(STEER_LIMIT);
    localparam logic signed [WW-1:0] LIM_LO = -WW'(STEER_LIMIT);
    localparam logic signed [IW-1:0] ACC_MAX = {1'b0, {(IW-1){1'b1}}};
    localparam logic signed [IW-1:0] ACC_MIN = {1'b1, {(IW-1){1'b0}}};

    logic                       r_out_valid;
    logic signed [STEER_W-1:0]  r_steer;
    logic                       r_sat;
    logic signed [IW-1:0]       r_integ;
    logic signed [ERR_W-1:0]    r_prev_err;

    logic signed [IW-1:0]       integ_half;
    logic signed [IW:0]         acc_raw;
    logic signed [IW-1:0]       n_integ;
    logic signed [ERR_W:0]      diff;
    logic signed [GAIN_W:0]     gp, gi, gd;
    logic signed [GAIN_W+ERR_W:0]   p_prop;
    logic signed [GAIN_W+IW:0]      p_integ;
    logic signed [GAIN_W+ERR_W+1:0] p_deriv;
    logic signed [SW-1:0]       sum;
    logic signed [SW-1:0]       biased;
    logic signed [SW-1:0]       shifted;
    logic signed [WW-1:0]       whole;
    logic signed [STEER_W-1:0]  n_steer;
    logic                       n_sat;
    logic                       fire;

    // leaky integral: error plus half the old integral, halving toward zero
    always_comb begin
        integ_half = (r_integ + $signed({{(IW-1){1'b0}}, r_integ[IW-1]})) >>> 1;
        acc_raw    = ((IW+1)'(i_err) <<< INTEG_FRAC_BITS) + (IW+1)'(integ_half);
        if (acc_raw[IW] != acc_raw[IW-1]) begin
            n_integ = acc_raw[IW] ? ACC_MIN : ACC_MAX;
        end else begin
            n_integ = acc_raw[IW-1:0];
        end
    end

    // three gain products, summed with full fraction
    always_comb begin
        diff    = (ERR_W+1)'(i_err) - (ERR_W+1)'(r_prev_err);
        gp      = $signed({1'b0, i_cfg.gain_prop});
        gi      = $signed({1'b0, i_cfg.gain_integ});
        gd      = $signed({1'b0, i_cfg.gain_deriv});
        p_prop  = gp * i_err;
        p_integ = gi * n_integ;
        p_deriv = gd * diff;
        sum     = (SW'(p_prop) <<< INTEG_FRAC_BITS) + SW'(p_integ)
                + (SW'(p_deriv) <<< INTEG_FRAC_BITS);
    end

    // truncate toward zero, then clamp to the steer range
    always_comb begin
        biased  = sum + (sum[SW-1] ? BIAS : '0);
        shifted = biased >>> FB;
        whole   = shifted[WW-1:0];
        if (whole > LIM_HI) begin
            n_steer = STEER_W'(STEER_LIMIT);
            n_sat   = 1'b1;
        end else if (whole < LIM_LO) begin
            n_steer = -STEER_W'(STEER_LIMIT);
            n_sat   = 1'b1;
        end else begin
            n_steer = whole[STEER_W-1:0];
            n_sat   = 1'b0;
        end
    end

    assign o_adv = !r_out_valid || i_ready;
    assign fire  = i_valid && o_adv;

    // result register and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_prev_err  <= '0;
        end else begin
            if (o_adv) begin
                r_out_valid <= i_valid;
            end
            if (fire) begin
                r_integ    <= n_integ;
                r_prev_err <= i_err;
            end
        end
        if (fire) begin
            r_steer <= n_steer;
            r_sat   <= n_sat;
        end
    end

    assign o_valid = r_out_valid;
    assign o_steer = r_steer;
    assign o_sat   = r_sat;

endmodule

[design/line_follow_pid_steer.sv]
// top level of the line-follow pid steering controller
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata[6:0] light_sample
//  m_axis    out  m_axis_tvalid/tready        tdata[8:0] steer_ratio, tuser[0] saturated
//  cfg       in   i_cfg_we (no wait)          i_cfg_idx register, i_cfg_data value
//
//  one request per cycle sustained while m_axis_tready stays high
//  stage one registers the error, stage two does the integral and the three
//  multiplies in one pass into the result register
//  reset (i_rst_n low, synchronous) clears the integral, previous error and valids
//  a stalled result holds both stages; ready flows back through each stage
module line_follow_pid_steer
    import lfps_pkg::*;
#(
    parameter int GAIN_FRAC_BITS  = 12,
    parameter int INTEG_FRAC_BITS = 8
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream: [6:0] light_sample, [7] zero
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,
    // output stream: [8:0] steer_ratio, [15:9] zero
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,
    // [0] saturated
    output logic [0:0]            m_axis_tuser
);

    t_cfg                      r_cfg;
    logic                      adv;
    logic                      err_valid;
    logic signed [ERR_W-1:0]   err;
    logic signed [STEER_W-1:0] steer;
    logic                      sat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.white_level <= WHITE_RST;
            r_cfg.black_level <= BLACK_RST;
            r_cfg.gain_prop   <= GAIN_PROP_RST;
            r_cfg.gain_integ  <= GAIN_INTEG_RST;
            r_cfg.gain_deriv  <= GAIN_DERIV_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WHITE_LEVEL: r_cfg.white_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_BLACK_LEVEL: r_cfg.black_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_GAIN_PROP:   r_cfg.gain_prop   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_INTEG:  r_cfg.gain_integ  <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_DERIV:  r_cfg.gain_deriv  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // error stage
    lfps_err u_err (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_sample (s_axis_tdata[LEVEL_W-1:0]),
        .i_adv    (adv),
        .o_valid  (err_valid),
        .o_err    (err)
    );

    // pid stage
    lfps_pid #(
        .GAIN_FRAC_BITS  (GAIN_FRAC_BITS),
        .INTEG_FRAC_BITS (INTEG_FRAC_BITS)
    ) u_pid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (err_valid),
        .i_err   (err),
        .o_adv   (adv),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_steer (steer),
        .o_sat   (sat)
    );

    assign m_axis_tdata = {7'd0, steer};
    assign m_axis_tuser = sat;

endmodule
